[hdl/atla_pkg.sv]
package atla_pkg;

  localparam int ENTRIES_DEF = 64;

  localparam int OPW  = 3;
  localparam int TW   = 32;
  localparam int AW   = 32;
  localparam int EIW  = 6;
  localparam int STW  = 8;
  localparam int LTW  = 31;
  localparam int SSW  = 2;
  localparam int CIW  = 8;
  localparam int CDW  = 32;
  localparam int IN_DW  = 80;
  localparam int OUT_DW = 16;

  localparam logic [OPW-1:0] OP_ADD    = 3'd0;
  localparam logic [OPW-1:0] OP_FIND   = 3'd1;
  localparam logic [OPW-1:0] OP_TOUCH  = 3'd2;
  localparam logic [OPW-1:0] OP_SETST  = 3'd3;
  localparam logic [OPW-1:0] OP_DELETE = 3'd4;

  localparam logic [SSW-1:0] ST_DONE  = 2'd0;
  localparam logic [SSW-1:0] ST_MISS  = 2'd1;
  localparam logic [SSW-1:0] ST_NOTUSE = 2'd2;

  localparam logic [CIW-1:0] REG_LIFETIME = 8'd0;
  localparam logic [CIW-1:0] REG_INIT_ST  = 8'd1;

  localparam logic [TW-1:0]  LIFETIME_RST = 32'd1000;

  // controller steps
  localparam int SPW = 4;
  localparam logic [SPW-1:0] S_IDLE   = 4'd0;
  localparam logic [SPW-1:0] S_DISP   = 4'd1;
  localparam logic [SPW-1:0] S_SW_RD  = 4'd2;
  localparam logic [SPW-1:0] S_SW_EV  = 4'd3;
  localparam logic [SPW-1:0] S_AL_CHK = 4'd4;
  localparam logic [SPW-1:0] S_EV_RD  = 4'd5;
  localparam logic [SPW-1:0] S_EV_WR  = 4'd6;
  localparam logic [SPW-1:0] S_AL_RD  = 4'd7;
  localparam logic [SPW-1:0] S_AL_WR  = 4'd8;
  localparam logic [SPW-1:0] S_LINK   = 4'd9;
  localparam logic [SPW-1:0] S_FIND   = 4'd10;
  localparam logic [SPW-1:0] S_FLAST  = 4'd11;
  localparam logic [SPW-1:0] S_FEND   = 4'd12;
  localparam logic [SPW-1:0] S_E_RD   = 4'd13;
  localparam logic [SPW-1:0] S_E_WR   = 4'd14;
  localparam logic [SPW-1:0] S_OUT    = 4'd15;

  typedef struct packed {
    logic [SPW-1:0] step;
    logic           accept;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic is_find;
    logic is_entry;
    logic is_touch;
    logic entry_ok;
    logic sweep_due;
    logic cur_valid;
    logic expired;
    logic need_evict;
    logic scan_last;
  } sts_t;

  function automatic logic is_after(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW-1:0] d;
    d = b - a;
    return d[TW-1];
  endfunction

endpackage

[hdl/atla_ctrl.sv]
module atla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_ready,
  input  atla_pkg::sts_t sts,
  output atla_pkg::cmd_t cmd,
  output logic          in_ready,
  output logic          out_valid
);

  logic [atla_pkg::SPW-1:0] state;
  logic [atla_pkg::SPW-1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      atla_pkg::S_IDLE: begin
        if (in_valid) state_next = atla_pkg::S_DISP;
      end
      atla_pkg::S_DISP: begin
        if (sts.is_add) begin
          state_next = sts.sweep_due ? atla_pkg::S_SW_RD : atla_pkg::S_AL_CHK;
        end else if (sts.is_find) begin
          state_next = atla_pkg::S_FIND;
        end else if (sts.is_entry && sts.entry_ok) begin
          state_next = atla_pkg::S_E_RD;
        end else begin
          state_next = atla_pkg::S_OUT;
        end
      end
      atla_pkg::S_SW_RD:  state_next = sts.cur_valid ? atla_pkg::S_SW_EV : atla_pkg::S_AL_CHK;
      atla_pkg::S_SW_EV:  state_next = sts.expired ? atla_pkg::S_SW_RD : atla_pkg::S_AL_CHK;
      atla_pkg::S_AL_CHK: state_next = sts.need_evict ? atla_pkg::S_EV_RD : atla_pkg::S_AL_RD;
      atla_pkg::S_EV_RD:  state_next = atla_pkg::S_EV_WR;
      atla_pkg::S_EV_WR:  state_next = atla_pkg::S_AL_RD;
      atla_pkg::S_AL_RD:  state_next = atla_pkg::S_AL_WR;
      atla_pkg::S_AL_WR:  state_next = atla_pkg::S_LINK;
      atla_pkg::S_LINK:   state_next = atla_pkg::S_OUT;
      atla_pkg::S_FIND:   state_next = sts.scan_last ? atla_pkg::S_FLAST : atla_pkg::S_FIND;
      atla_pkg::S_FLAST:  state_next = atla_pkg::S_FEND;
      atla_pkg::S_FEND:   state_next = atla_pkg::S_OUT;
      atla_pkg::S_E_RD:   state_next = atla_pkg::S_E_WR;
      atla_pkg::S_E_WR:   state_next = sts.is_touch ? atla_pkg::S_LINK : atla_pkg::S_OUT;
      atla_pkg::S_OUT: begin
        if (out_ready) state_next = atla_pkg::S_IDLE;
      end
      default: state_next = atla_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atla_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready   = (state == atla_pkg::S_IDLE);
  assign out_valid  = (state == atla_pkg::S_OUT);
  assign cmd.step   = state;
  assign cmd.accept = in_ready && in_valid;

endmodule

[hdl/atla_dp.sv]
module atla_dp #(
  parameter int ENTRIES = atla_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  atla_pkg::cmd_t            cmd,
  output atla_pkg::sts_t            sts,
  input  logic [atla_pkg::OPW-1:0]  in_opcode,
  input  logic [atla_pkg::TW-1:0]   in_now,
  input  logic [atla_pkg::AW-1:0]   in_address,
  input  logic [atla_pkg::EIW-1:0]  in_entry_index,
  input  logic                      in_static_flag,
  input  logic [atla_pkg::STW-1:0]  in_new_state,
  input  logic                      cfg_write,
  input  logic [atla_pkg::CIW-1:0]  cfg_addr,
  input  logic [atla_pkg::CDW-1:0]  cfg_wdata,
  output logic [atla_pkg::SSW-1:0]  res_status,
  output logic [atla_pkg::EIW-1:0]  res_index,
  output logic [atla_pkg::STW-1:0]  res_state,
  output logic                      res_static,
  output logic                      res_evicted
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // entry memories
  logic [atla_pkg::AW-1:0]  m_addr  [ENTRIES];
  logic [atla_pkg::TW-1:0]  m_tout  [ENTRIES];
  logic [atla_pkg::STW-1:0] m_state [ENTRIES];
  logic                     m_stat  [ENTRIES];
  logic [atla_pkg::TW-1:0]  m_alloc [ENTRIES];
  logic [IW-1:0]            m_prev  [ENTRIES];
  logic [IW-1:0]            m_next  [ENTRIES];
  logic [IW-1:0]            m_free  [ENTRIES];

  logic [atla_pkg::AW-1:0]  q_addr;
  logic [atla_pkg::TW-1:0]  q_tout;
  logic [atla_pkg::STW-1:0] q_state;
  logic                     q_stat;
  logic [atla_pkg::TW-1:0]  q_alloc;
  logic [IW-1:0]            q_prev;
  logic [IW-1:0]            q_next;
  logic [IW-1:0]            q_free;

  logic [ENTRIES-1:0]       valid;
  logic [IW-1:0]            head;
  logic [IW-1:0]            tail;
  logic [CW-1:0]            lcnt;
  logic [CW-1:0]            fcnt;
  logic [CW-1:0]            fresh;
  logic [atla_pkg::TW-1:0]  next_sweep;
  logic [atla_pkg::TW-1:0]  add_seq;
  logic [atla_pkg::LTW-1:0] lifetime;
  logic [atla_pkg::STW-1:0] init_state;

  logic [atla_pkg::OPW-1:0] i_op;
  logic [atla_pkg::TW-1:0]  i_now;
  logic [atla_pkg::AW-1:0]  i_addr;
  logic [atla_pkg::EIW-1:0] i_eidx;
  logic                     i_sflag;
  logic [atla_pkg::STW-1:0] i_nstate;

  logic [IW-1:0]            cur;
  logic                     cv;
  logic [IW-1:0]            lidx;
  logic [IW-1:0]            k;
  logic [IW-1:0]            qk;
  logic                     pv;
  logic                     hit;
  logic [IW-1:0]            best;
  logic [atla_pkg::TW-1:0]  best_d;
  logic [atla_pkg::STW-1:0] best_state;
  logic                     best_stat;

  logic [31:0]              eidx_w;
  logic [IW-1:0]            e_ix;
  logic [IW-1:0]            raddr;
  logic [IW-1:0]            aidx;
  logic [31:0]              aidx_w;
  logic [31:0]              best_w;
  logic [atla_pkg::TW-1:0]  deadline;
  logic [atla_pkg::TW-1:0]  seq_gap;
  logic                     expired;
  logic                     match;

  logic                     do_unlink;
  logic                     push_free;
  logic [IW-1:0]            ul_e;
  logic                     nx_we;
  logic [IW-1:0]            nx_wa;
  logic [IW-1:0]            nx_wd;
  logic                     pv_we;
  logic [IW-1:0]            pv_wa;
  logic [IW-1:0]            pv_wd;
  logic [CW-1:0]            fcnt_dec;

  assign eidx_w   = 32'(i_eidx);
  assign e_ix     = eidx_w[IW-1:0];
  assign deadline = i_now + {1'b0, lifetime};
  assign expired  = atla_pkg::is_after(i_now, q_tout);
  assign aidx     = (fcnt != '0) ? q_free : fresh[IW-1:0];
  assign aidx_w   = 32'(aidx);
  assign best_w   = 32'(best);
  assign seq_gap  = add_seq - q_alloc;
  assign match    = pv && valid[qk] && (q_addr == i_addr);
  assign fcnt_dec = fcnt - CW'(1);

  assign sts.is_add     = (i_op == atla_pkg::OP_ADD);
  assign sts.is_find    = (i_op == atla_pkg::OP_FIND);
  assign sts.is_entry   = (i_op == atla_pkg::OP_TOUCH) || (i_op == atla_pkg::OP_SETST) ||
                          (i_op == atla_pkg::OP_DELETE);
  assign sts.is_touch   = (i_op == atla_pkg::OP_TOUCH);
  assign sts.entry_ok   = (eidx_w < ENTRIES) && valid[e_ix];
  assign sts.sweep_due  = atla_pkg::is_after(i_now, next_sweep);
  assign sts.cur_valid  = cv;
  assign sts.expired    = expired;
  assign sts.need_evict = (fcnt == '0) && (fresh == CW'(ENTRIES)) && (lcnt != '0);
  assign sts.scan_last  = (k == IW'(ENTRIES - 1));

  always_comb begin
    case (cmd.step)
      atla_pkg::S_SW_RD: raddr = cur;
      atla_pkg::S_EV_RD: raddr = head;
      atla_pkg::S_E_RD:  raddr = e_ix;
      default:           raddr = k;
    endcase
  end

  // list maintenance: unlink one node, or link lidx as newest
  always_comb begin
    do_unlink = 1'b0;
    ul_e      = e_ix;
    nx_we = 1'b0; nx_wa = tail; nx_wd = lidx;
    pv_we = 1'b0; pv_wa = lidx; pv_wd = tail;
    case (cmd.step)
      atla_pkg::S_SW_EV: begin
        do_unlink = expired && !q_stat;
        ul_e      = cur;
      end
      atla_pkg::S_EV_WR: begin
        do_unlink = 1'b1;
        ul_e      = head;
      end
      atla_pkg::S_E_WR: begin
        do_unlink = (i_op == atla_pkg::OP_TOUCH) || (i_op == atla_pkg::OP_DELETE);
        ul_e      = e_ix;
      end
      atla_pkg::S_LINK: begin
        pv_we = 1'b1;
        nx_we = (lcnt != '0);
      end
      default: begin
      end
    endcase
    if (do_unlink) begin
      if (ul_e != head) begin
        nx_we = 1'b1; nx_wa = q_prev; nx_wd = q_next;
      end
      if (ul_e != tail) begin
        pv_we = 1'b1; pv_wa = q_next; pv_wd = q_prev;
      end
    end
  end

  assign push_free = do_unlink &&
                     !((cmd.step == atla_pkg::S_E_WR) && (i_op == atla_pkg::OP_TOUCH));

  // memories
  always_ff @(posedge clk) begin
    q_addr  <= m_addr[raddr];
    q_tout  <= m_tout[raddr];
    q_state <= m_state[raddr];
    q_stat  <= m_stat[raddr];
    q_alloc <= m_alloc[raddr];
    q_prev  <= m_prev[raddr];
    q_next  <= m_next[raddr];
    q_free  <= m_free[fcnt_dec[IW-1:0]];
    if (nx_we) m_next[nx_wa] <= nx_wd;
    if (pv_we) m_prev[pv_wa] <= pv_wd;
    if (push_free) m_free[fcnt[IW-1:0]] <= ul_e;
    if (cmd.step == atla_pkg::S_AL_WR) begin
      m_addr[aidx]  <= i_addr;
      m_tout[aidx]  <= deadline;
      m_stat[aidx]  <= i_sflag;
      m_alloc[aidx] <= add_seq + atla_pkg::TW'(1);
    end
    if (cmd.step == atla_pkg::S_AL_WR) begin
      m_state[aidx] <= init_state;
    end else if ((cmd.step == atla_pkg::S_E_WR) && (i_op == atla_pkg::OP_SETST)) begin
      m_state[e_ix] <= i_nstate;
    end
    if ((cmd.step == atla_pkg::S_E_WR) && (i_op == atla_pkg::OP_TOUCH)) begin
      m_tout[e_ix] <= deadline;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      i_op     <= in_opcode;
      i_now    <= in_now;
      i_addr   <= in_address;
      i_eidx   <= in_entry_index;
      i_sflag  <= in_static_flag;
      i_nstate <= in_new_state;
    end
    qk <= k;
    case (cmd.step)
      atla_pkg::S_DISP: begin
        cur         <= head;
        res_status  <= (sts.is_entry && !sts.entry_ok) ? atla_pkg::ST_NOTUSE : atla_pkg::ST_DONE;
        res_index   <= (sts.is_entry && !sts.entry_ok) ? i_eidx : '0;
        res_state   <= '0;
        res_static  <= 1'b0;
        res_evicted <= 1'b0;
      end
      atla_pkg::S_SW_EV: cur <= q_next;
      atla_pkg::S_EV_WR: res_evicted <= 1'b1;
      atla_pkg::S_AL_WR: begin
        lidx       <= aidx;
        res_index  <= aidx_w[atla_pkg::EIW-1:0];
        res_state  <= init_state;
        res_static <= i_sflag;
      end
      atla_pkg::S_E_WR: begin
        lidx       <= e_ix;
        res_index  <= i_eidx;
        res_state  <= (i_op == atla_pkg::OP_SETST) ? i_nstate : q_state;
        res_static <= q_stat;
      end
      atla_pkg::S_FEND: begin
        res_status <= hit ? atla_pkg::ST_DONE : atla_pkg::ST_MISS;
        res_index  <= hit ? best_w[atla_pkg::EIW-1:0] : '0;
        res_state  <= hit ? best_state : '0;
        res_static <= hit && best_stat;
      end
      default: begin
      end
    endcase
    // keep the newest matching entry
    if (match && (!hit || (seq_gap < best_d))) begin
      best       <= qk;
      best_d     <= seq_gap;
      best_state <= q_state;
      best_stat  <= q_stat;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      head       <= '0;
      tail       <= '0;
      lcnt       <= '0;
      fcnt       <= '0;
      fresh      <= '0;
      next_sweep <= '0;
      add_seq    <= '0;
      lifetime   <= atla_pkg::LIFETIME_RST[atla_pkg::LTW-1:0];
      init_state <= '0;
      cv         <= 1'b0;
      k          <= '0;
      pv         <= 1'b0;
      hit        <= 1'b0;
    end else begin
      if (cfg_write && (cfg_addr == atla_pkg::REG_LIFETIME)) begin
        lifetime <= cfg_wdata[atla_pkg::LTW-1:0];
      end
      if (cfg_write && (cfg_addr == atla_pkg::REG_INIT_ST)) begin
        init_state <= cfg_wdata[atla_pkg::STW-1:0];
      end
      pv <= (cmd.step == atla_pkg::S_FIND);
      if (match) hit <= 1'b1;
      case (cmd.step)
        atla_pkg::S_DISP: begin
          cv  <= (lcnt != '0);
          k   <= '0;
          hit <= 1'b0;
        end
        atla_pkg::S_SW_RD: begin
          if (!cv) next_sweep <= deadline;
        end
        atla_pkg::S_SW_EV: begin
          cv <= (cur != tail);
          if (!expired) next_sweep <= q_tout;
        end
        atla_pkg::S_FIND: k <= k + IW'(1);
        atla_pkg::S_AL_WR: begin
          if (fcnt != '0) begin
            fcnt <= fcnt_dec;
          end else begin
            fresh <= fresh + CW'(1);
          end
          valid[aidx] <= 1'b1;
          add_seq     <= add_seq + atla_pkg::TW'(1);
        end
        atla_pkg::S_LINK: begin
          if (lcnt == '0) head <= lidx;
          tail <= lidx;
          lcnt <= lcnt + CW'(1);
        end
        default: begin
        end
      endcase
      if (do_unlink) begin
        lcnt <= lcnt - CW'(1);
        if (ul_e == head) head <= q_next;
        if (ul_e == tail) tail <= q_prev;
      end
      if (push_free) begin
        valid[ul_e] <= 1'b0;
        fcnt        <= fcnt + CW'(1);
      end
    end
  end

endmodule

[hdl/address_tracking_table_lru_aging.sv]
// channel  | valid / ready      | payload
// ---------+--------------------+------------------------------------------------
// input    | s_tvalid/s_tready  | s_tuser opcode; s_tdata now, address, index...
// result   | m_tvalid/m_tready  | m_tuser status; m_tdata index, state, flags
// config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item at a time. Find walks every entry through one memory read port.
// Add first runs the aging sweep from the oldest entry when it is due, then
// evicts the least recently used entry if the table is full, then allocates.
// Reset is synchronous and needs no clearing pass; the table starts empty.
// The result register holds until m_tready; no new item is taken before.
module address_tracking_table_lru_aging #(
  parameter int ENTRIES = atla_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [31:0] now, [63:32] address, [69:64] entry_index, [70] static_flag,
  // [78:71] new_state, [79] zero
  input  logic [atla_pkg::IN_DW-1:0]    s_tdata,
  // [2:0] opcode
  input  logic [atla_pkg::OPW-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [5:0] result_index, [13:6] result_state, [14] result_static, [15] evicted
  output logic [atla_pkg::OUT_DW-1:0]   m_tdata,
  // [1:0] status
  output logic [atla_pkg::SSW-1:0]     m_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [atla_pkg::CIW-1:0]     cfg_index,
  input  logic [atla_pkg::CDW-1:0]     cfg_data
);

  atla_pkg::cmd_t cmd;
  atla_pkg::sts_t sts;

  logic [atla_pkg::SSW-1:0] res_status;
  logic [atla_pkg::EIW-1:0] res_index;
  logic [atla_pkg::STW-1:0] res_state;
  logic                     res_static;
  logic                     res_evicted;

  assign cfg_ready = 1'b1;

  atla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid)
  );

  atla_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (s_tuser),
    .in_now         (s_tdata[31:0]),
    .in_address     (s_tdata[63:32]),
    .in_entry_index (s_tdata[69:64]),
    .in_static_flag (s_tdata[70]),
    .in_new_state   (s_tdata[78:71]),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_addr       (cfg_index),
    .cfg_wdata      (cfg_data),
    .res_status     (res_status),
    .res_index      (res_index),
    .res_state      (res_state),
    .res_static     (res_static),
    .res_evicted    (res_evicted)
  );

  assign m_tdata = {res_evicted, res_static, res_state, res_index};
  assign m_tuser = res_status;

endmodule

[sim/address_tracking_table_lru_aging_tb.sv]
module address_tracking_table_lru_aging_tb;
  import atla_pkg::*;

  localparam int N = ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [SSW-1:0] status;
    logic [EIW-1:0] idx;
    logic [STW-1:0] state;
    logic           stat;
    logic           evicted;
  } table_result_t;

  typedef struct packed {
    logic [OPW-1:0] op;
    logic [TW-1:0]  now;
    logic [AW-1:0]  addr;
    logic [EIW-1:0] eidx;
    logic           sflag;
    logic [STW-1:0] nst;
  } table_op_t;

  typedef struct packed {
    table_op_t     item;
    logic          typed;
    table_result_t res;
  } stim_row_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
  logic [IN_DW-1:0] s_tdata;
  logic [OPW-1:0] s_tuser;
  logic [OUT_DW-1:0] m_tdata;
  logic [SSW-1:0] m_tuser;
  logic [CIW-1:0] cfg_index;
  logic [CDW-1:0] cfg_data;

  address_tracking_table_lru_aging DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // table shadow
  logic [LTW-1:0] life;
  logic [STW-1:0] init_st;
  logic           vld [N];
  logic [AW-1:0]  e_addr [N];
  logic [TW-1:0]  e_tmo [N];
  logic [STW-1:0] e_st [N];
  logic           e_stat [N];
  logic [31:0]    e_seq [N];
  int             lru_q[$];
  int             free_q[$];
  logic [TW-1:0]  sweep_mark;
  logic [31:0]    seq_cnt;

  table_result_t pending_q[$];
  int   fails;
  int   mode;
  int   cycles;
  stim_row_t dir_tab[20];
  logic [AW-1:0] addr_pool[8];

  function automatic logic later(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW-1:0] d;
    d = b - a;
    return d[TW-1];
  endfunction

  function automatic table_result_t apply_op(input table_op_t it);
    table_result_t r;
    logic [TW-1:0] mark;
    int pos, e, best;
    logic hit;
    logic [31:0] d, best_d;
    r = '0;
    case (it.op)
      OP_ADD: begin
        if (later(it.now, sweep_mark)) begin
          mark = it.now + {1'b0, life};
          pos = 0;
          while (pos < lru_q.size()) begin
            e = lru_q[pos];
            if (later(it.now, e_tmo[e])) begin
              if (e_stat[e]) pos++;
              else begin
                lru_q.delete(pos);
                vld[e] = 0;
                free_q.push_back(e);
              end
            end else begin
              mark = e_tmo[e];
              break;
            end
          end
          sweep_mark = mark;
        end
        if (free_q.size() == 0 && lru_q.size() > 0) begin
          e = lru_q.pop_front();
          vld[e] = 0;
          free_q.push_back(e);
          r.evicted = 1;
        end
        if (free_q.size() > 0) begin
          e = free_q.pop_back();
          vld[e] = 1;
          lru_q.push_back(e);
          e_tmo[e] = it.now + {1'b0, life};
          e_st[e] = init_st;
          e_addr[e] = it.addr;
          e_stat[e] = it.sflag;
          seq_cnt++;
          e_seq[e] = seq_cnt;
          r.idx = EIW'(e);
          r.state = init_st;
          r.stat = it.sflag;
        end
      end
      OP_FIND: begin
        hit = 0; best = 0; best_d = 0;
        for (int k = 0; k < N; k++)
          if (vld[k] && e_addr[k] == it.addr) begin
            d = seq_cnt - e_seq[k];
            if (!hit || d < best_d) begin
              hit = 1; best = k; best_d = d;
            end
          end
        if (hit) begin
          r.idx = EIW'(best);
          r.state = e_st[best];
          r.stat = e_stat[best];
        end else r.status = ST_MISS;
      end
      OP_TOUCH, OP_SETST, OP_DELETE: begin
        e = int'(it.eidx);
        r.idx = it.eidx;
        if (!vld[e]) r.status = ST_NOTUSE;
        else begin
          if (it.op == OP_TOUCH) begin
            foreach (lru_q[k]) if (lru_q[k] == e) begin lru_q.delete(k); break; end
            lru_q.push_back(e);
            e_tmo[e] = it.now + {1'b0, life};
          end else if (it.op == OP_SETST) e_st[e] = it.nst;
          else begin
            foreach (lru_q[k]) if (lru_q[k] == e) begin lru_q.delete(k); break; end
            vld[e] = 0;
            free_q.push_back(e);
            e_tmo[e] = '0;
          end
          r.state = e_st[e];
          r.stat = e_stat[e];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("address_tracking_table_lru_aging: mismatch");
      $finish;
    end
  end

  // result side: random stall and compare against oldest expectation
  always @(posedge clk) begin
    table_result_t act, exp_r;
    if (rst) m_tready <= 0;
    else begin
      if (m_tvalid && m_tready) begin
        act = {m_tuser, m_tdata[5:0], m_tdata[13:6], m_tdata[14], m_tdata[15]};
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected item %h", $time, act);
          fails++;
        end else begin
          exp_r = pending_q.pop_front();
          if (act !== exp_r) begin
            $display("%0t: expected st=%0d idx=%0d state=%0h static=%0b ev=%0b, got st=%0d idx=%0d state=%0h static=%0b ev=%0b",
                     $time, exp_r.status, exp_r.idx, exp_r.state, exp_r.stat, exp_r.evicted,
                     act.status, act.idx, act.state, act.stat, act.evicted);
            fails++;
          end
        end
      end
      case (mode)
        0: m_tready <= ($urandom_range(0, 99) >= 80);
        1: m_tready <= ($urandom_range(0, 99) >= 11);
        default: m_tready <= 1;
      endcase
    end
  end

  task automatic send(input table_op_t it, input logic typed, input table_result_t typed_res);
    table_result_t pr;
    s_tvalid <= 1;
    s_tuser <= it.op;
    s_tdata <= {1'b0, it.nst, it.sflag, it.eidx, it.addr, it.now};
    do @(posedge clk); while (!s_tready);
    pr = apply_op(it);
    pending_q.push_back(typed ? typed_res : pr);
    if ((mode == 0 && $urandom_range(0, 99) < 11) || (mode == 1 && $urandom_range(0, 99) < 80)) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == REG_LIFETIME) life = val[LTW-1:0];
    else if (idx == REG_INIT_ST) init_st = val[STW-1:0];
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic rand_op(output table_op_t it, inout logic [TW-1:0] clock_now);
    int w, pick;
    int live[$];
    it.sflag = ($urandom_range(0, 9) == 0);
    it.nst = STW'($urandom);
    w = $urandom_range(0, 99);
    if (w < 36) it.op = OP_ADD;
    else if (w < 56) it.op = OP_FIND;
    else if (w < 71) it.op = OP_TOUCH;
    else if (w < 81) it.op = OP_SETST;
    else if (w < 95) it.op = OP_DELETE;
    else it.op = OPW'($urandom_range(5, 7));
    if ($urandom_range(0, 49) == 0) clock_now = $urandom;
    else if (life < 2000) clock_now += $urandom_range(0, 2 * life + 2);
    else clock_now += $urandom_range(0, 3000);
    it.now = clock_now;
    it.addr = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)];
    for (int k = 0; k < N; k++) if (vld[k]) live.push_back(k);
    if (live.size() > 0 && $urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, live.size() - 1);
      it.eidx = EIW'(live[pick]);
    end else it.eidx = EIW'($urandom);
  endtask

  initial begin
    table_op_t it;
    logic [TW-1:0] clock_now;
    logic [CDW-1:0] lt_val [6];
    logic [CDW-1:0] is_val [6];
    rst = 1; fails = 0; mode = 0; cycles = 0;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    life = LIFETIME_RST[LTW-1:0]; init_st = '0;
    for (int k = 0; k < N; k++) begin
      vld[k] = 0; e_addr[k] = '0; e_tmo[k] = '0; e_st[k] = '0; e_stat[k] = 0; e_seq[k] = '0;
      free_q.push_back(N - 1 - k);
    end
    sweep_mark = '0; seq_cnt = '0;

    dir_tab[0]  = '{'{OP_FIND,   32'd0, 32'h1234, 6'd0, 1'b0, 8'd0}, 1, '{ST_MISS, 0, 0, 0, 0}};
    dir_tab[1]  = '{'{OP_TOUCH,  32'd0, 32'd0, 6'd5, 1'b0, 8'd0}, 1, '{ST_NOTUSE, 5, 0, 0, 0}};
    dir_tab[2]  = '{'{OP_SETST,  32'd0, 32'd0, 6'd63, 1'b1, 8'hff}, 1,
                    '{ST_NOTUSE, 63, 0, 0, 0}};
    dir_tab[3]  = '{'{OP_DELETE, 32'd0, 32'd0, 6'd0, 1'b0, 8'd0}, 1, '{ST_NOTUSE, 0, 0, 0, 0}};
    dir_tab[4]  = '{'{3'd7, 32'hffffffff, 32'hffffffff, 6'd63, 1'b1, 8'hff}, 1, '0};
    dir_tab[5]  = '{'{3'd5, 32'd0, 32'd0, 6'd0, 1'b0, 8'd0}, 1, '0};
    dir_tab[6]  = '{'{3'd6, 32'd0, 32'd0, 6'd0, 1'b0, 8'd0}, 1, '0};
    dir_tab[7]  = '{'{OP_ADD, 32'd0, 32'd0, 6'd0, 1'b0, 8'd0}, 1, '{ST_DONE, 0, 0, 0, 0}};
    dir_tab[8]  = '{'{OP_ADD, 32'hffffffff, 32'hffffffff, 6'd0, 1'b1, 8'd0}, 1,
                    '{ST_DONE, 1, 0, 1, 0}};
    dir_tab[9]  = '{'{OP_FIND, 32'd0, 32'hffffffff, 6'd0, 1'b0, 8'd0}, 1, '{ST_DONE, 1, 0, 1, 0}};
    dir_tab[10] = '{'{OP_FIND, 32'd0, 32'd0, 6'd0, 1'b0, 8'd0}, 1, '{ST_DONE, 0, 0, 0, 0}};
    dir_tab[11] = '{'{OP_SETST, 32'd0, 32'd0, 6'd0, 1'b0, 8'hff}, 1, '{ST_DONE, 0, 8'hff, 0, 0}};
    dir_tab[12] = '{'{OP_TOUCH, 32'd500, 32'd0, 6'd1, 1'b0, 8'd0}, 0, '0};
    // sweep frees the expired plain entry, skips the static one
    dir_tab[13] = '{'{OP_ADD, 32'd2000, 32'd0, 6'd0, 1'b0, 8'd0}, 0, '0};
    dir_tab[14] = '{'{OP_FIND, 32'd2000, 32'd0, 6'd0, 1'b0, 8'd0}, 0, '0};
    dir_tab[15] = '{'{OP_DELETE, 32'd2000, 32'd0, 6'd1, 1'b0, 8'd0}, 0, '0};
    dir_tab[16] = '{'{OP_DELETE, 32'd2000, 32'd0, 6'd1, 1'b0, 8'd0}, 1, '{ST_NOTUSE, 1, 0, 0, 0}};
    dir_tab[17] = '{'{OP_ADD, 32'h80000000, 32'ha5a5a5a5, 6'h3f, 1'b1, 8'hff}, 0, '0};
    dir_tab[18] = '{'{OP_FIND, 32'h80000000, 32'ha5a5a5a5, 6'd0, 1'b0, 8'd0}, 0, '0};
    dir_tab[19] = '{'{OP_TOUCH, 32'h80000001, 32'd0, 6'h3f, 1'b0, 8'd0}, 0, '0};

    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_reg(REG_LIFETIME, 32'd1000);
    write_reg(REG_INIT_ST, 32'd0);
    foreach (dir_tab[k]) send(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].res);
    drain();

    lt_val = '{32'd1, 32'hffffffff, 32'd1000, 32'd37, 32'h7fffffff, $urandom_range(2, 5000)};
    is_val = '{32'd0, 32'hffffffff, $urandom, 32'h0000005a, 32'hffffff00, $urandom};
    clock_now = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      mode = ph / 2;
      write_reg(REG_LIFETIME, lt_val[ph] | ($urandom_range(0, 1) << 31));
      write_reg(REG_INIT_ST, is_val[ph]);
      foreach (addr_pool[k]) addr_pool[k] = $urandom;
      for (int n = 0; n < 190; n++) begin
        rand_op(it, clock_now);
        send(it, 0, '0);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (fails == 0) $display("address_tracking_table_lru_aging: match");
    else $display("address_tracking_table_lru_aging: mismatch");
    $finish;
  end

endmodule
